### sv/kslc_pkg.sv
// shared types, codes and constants of the keypad lock state controller
package kslc_pkg;

  localparam int TIME_BITS_DEF = 24;
  localparam int CFG_TIME_W    = 24;
  localparam int CFG_DATA_W    = 24;
  localparam int CFG_IDX_W     = 3;

  localparam logic [7:0] FAIL_MAX        = 8'd255;
  localparam logic [7:0] LED_FULL        = 8'd255;
  localparam logic [7:0] LED_AMBER_GREEN = 8'd80;

  // configuration reset values
  localparam logic [CFG_TIME_W-1:0] AUTO_LOCK_RST   = 24'd5000;
  localparam logic [CFG_TIME_W-1:0] ALARM_TIME_RST  = 24'd10000;
  localparam logic [7:0]            FAIL_LIMIT_RST  = 8'd3;
  localparam logic                  MANUAL_RST      = 1'b0;
  localparam logic [CFG_TIME_W-1:0] FB_TIME_RST     = 24'd1000;
  localparam logic [CFG_TIME_W-1:0] KEY_FB_TIME_RST = 24'd200;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO_LOCK   = 3'd0,
    CFG_ALARM_TIME  = 3'd1,
    CFG_FAIL_LIMIT  = 3'd2,
    CFG_MANUAL_MODE = 3'd3,
    CFG_FB_TIME     = 3'd4,
    CFG_KEY_FB_TIME = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_R_LOCK   = 3'd1,
    OP_R_UNLOCK = 3'd2,
    OP_PIN      = 3'd3,
    OP_KEY      = 3'd4,
    OP_CFG      = 3'd5,
    OP_SEC_CFG  = 3'd6
  } opcode_t;

  typedef enum logic [1:0] {
    LS_LOCKED   = 2'd0,
    LS_UNLOCKED = 2'd1,
    LS_ALARM    = 2'd2
  } lock_state_t;

  typedef enum logic [2:0] {
    FB_NONE     = 3'd0,
    FB_R_LOCK   = 3'd1,
    FB_R_UNLOCK = 3'd2,
    FB_CFG      = 3'd3,
    FB_SEC      = 3'd4,
    FB_WRONG    = 3'd5,
    FB_KEY      = 3'd6
  } fb_kind_t;

  typedef struct packed {
    logic [CFG_TIME_W-1:0] auto_lock_time;
    logic [CFG_TIME_W-1:0] alarm_time;
    logic [7:0]            fail_limit;
    logic                  manual_mode;
    logic [CFG_TIME_W-1:0] feedback_time;
    logic [CFG_TIME_W-1:0] key_feedback_time;
  } cfg_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       pin_ok;
  } in_word_t;

  typedef struct packed {
    logic [1:0] lock_state;
    logic [2:0] feedback_kind;
    logic [7:0] led_red;
    logic [7:0] led_green;
    logic [7:0] led_blue;
    logic       blink;
    logic [7:0] fail_count;
  } out_word_t;

  // indicator colour: alarm first, then feedback, then lock state
  function automatic logic [23:0] led_colour(lock_state_t ls, fb_kind_t fb);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = '0;
    g = '0;
    b = '0;
    if (ls == LS_ALARM) begin
      r = LED_FULL;
    end else begin
      case (fb)
        FB_R_LOCK:   r = LED_FULL;
        FB_R_UNLOCK: g = LED_FULL;
        FB_CFG: begin
          g = LED_FULL;
          b = LED_FULL;
        end
        FB_SEC: begin
          r = LED_FULL;
          g = LED_FULL;
        end
        FB_WRONG: begin
          r = LED_FULL;
          g = LED_AMBER_GREEN;
        end
        FB_KEY: begin
          r = LED_FULL;
          g = LED_FULL;
          b = LED_FULL;
        end
        default: begin
          if (ls == LS_LOCKED) r = LED_FULL;
          else if (ls == LS_UNLOCKED) g = LED_FULL;
        end
      endcase
    end
    return {r, g, b};
  endfunction

endpackage

### sv/kslc_cfg_regs.sv
// configuration register file of the keypad lock controller
module kslc_cfg_regs
  import kslc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_lock_time    <= AUTO_LOCK_RST;
      cfg.alarm_time        <= ALARM_TIME_RST;
      cfg.fail_limit        <= FAIL_LIMIT_RST;
      cfg.manual_mode       <= MANUAL_RST;
      cfg.feedback_time     <= FB_TIME_RST;
      cfg.key_feedback_time <= KEY_FB_TIME_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_AUTO_LOCK:   cfg.auto_lock_time    <= cfg_data[CFG_TIME_W-1:0];
        CFG_ALARM_TIME:  cfg.alarm_time        <= cfg_data[CFG_TIME_W-1:0];
        CFG_FAIL_LIMIT:  cfg.fail_limit        <= cfg_data[7:0];
        CFG_MANUAL_MODE: cfg.manual_mode       <= cfg_data[0];
        CFG_FB_TIME:     cfg.feedback_time     <= cfg_data[CFG_TIME_W-1:0];
        CFG_KEY_FB_TIME: cfg.key_feedback_time <= cfg_data[CFG_TIME_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### sv/kslc_core.sv
// lock state registers, event update and result word formation
module kslc_core
  import kslc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      accept,
  input  in_word_t  in_word,
  input  cfg_t      cfg,
  output out_word_t result
);

  // compare width covers both the counters and the configured durations
  localparam int CW = (TIME_BITS > CFG_TIME_W) ? TIME_BITS : CFG_TIME_W;
  localparam logic [TIME_BITS-1:0] T_MAX = '1;

  lock_state_t          lock_state, lock_state_next;
  fb_kind_t             feedback, feedback_next;
  logic [7:0]           fail_counter, fail_counter_next;
  logic [TIME_BITS-1:0] fb_elapsed, fb_elapsed_next;
  logic [TIME_BITS-1:0] unlock_elapsed, unlock_elapsed_next;
  logic [TIME_BITS-1:0] alarm_elapsed, alarm_elapsed_next;

  logic [TIME_BITS-1:0] fb_inc, unlock_inc, alarm_inc;
  logic [CFG_TIME_W-1:0] fb_dur;
  logic [7:0]           fail_inc;
  logic [23:0]          rgb;

  always_comb begin
    fb_inc     = (fb_elapsed == T_MAX) ? T_MAX : fb_elapsed + TIME_BITS'(1);
    unlock_inc = (unlock_elapsed == T_MAX) ? T_MAX : unlock_elapsed + TIME_BITS'(1);
    alarm_inc  = (alarm_elapsed == T_MAX) ? T_MAX : alarm_elapsed + TIME_BITS'(1);
    fb_dur     = (feedback == FB_KEY) ? cfg.key_feedback_time : cfg.feedback_time;
    fail_inc   = (fail_counter == FAIL_MAX) ? fail_counter : fail_counter + 8'd1;

    lock_state_next     = lock_state;
    feedback_next       = feedback;
    fail_counter_next   = fail_counter;
    fb_elapsed_next     = fb_elapsed;
    unlock_elapsed_next = unlock_elapsed;
    alarm_elapsed_next  = alarm_elapsed;

    case (opcode_t'(in_word.opcode))
      OP_TICK: begin
        fb_elapsed_next     = fb_inc;
        unlock_elapsed_next = unlock_inc;
        alarm_elapsed_next  = alarm_inc;
        if (feedback != FB_NONE && CW'(fb_inc) >= CW'(fb_dur))
          feedback_next = FB_NONE;
        if (lock_state == LS_UNLOCKED && !cfg.manual_mode &&
            CW'(unlock_inc) >= CW'(cfg.auto_lock_time))
          lock_state_next = LS_LOCKED;
        if (lock_state == LS_ALARM && CW'(alarm_inc) >= CW'(cfg.alarm_time))
          lock_state_next = LS_LOCKED;
      end
      OP_R_LOCK: begin
        if (lock_state != LS_ALARM) begin
          lock_state_next = LS_LOCKED;
          feedback_next   = FB_R_LOCK;
          fb_elapsed_next = '0;
        end
      end
      OP_R_UNLOCK: begin
        if (lock_state != LS_ALARM) begin
          lock_state_next     = LS_UNLOCKED;
          unlock_elapsed_next = '0;
          feedback_next       = FB_R_UNLOCK;
          fb_elapsed_next     = '0;
        end
      end
      OP_PIN: begin
        if (lock_state != LS_ALARM) begin
          if (in_word.pin_ok) begin
            fail_counter_next   = '0;
            lock_state_next     = LS_UNLOCKED;
            unlock_elapsed_next = '0;
          end else if (fail_inc >= cfg.fail_limit) begin
            lock_state_next    = LS_ALARM;
            alarm_elapsed_next = '0;
            fail_counter_next  = '0;
            feedback_next      = FB_NONE;
          end else begin
            fail_counter_next = fail_inc;
            feedback_next     = FB_WRONG;
            fb_elapsed_next   = '0;
          end
        end
      end
      OP_KEY: begin
        if (feedback == FB_NONE || feedback == FB_KEY) begin
          feedback_next   = FB_KEY;
          fb_elapsed_next = '0;
        end
      end
      OP_CFG: begin
        feedback_next   = FB_CFG;
        fb_elapsed_next = '0;
      end
      OP_SEC_CFG: begin
        feedback_next   = FB_SEC;
        fb_elapsed_next = '0;
      end
      default: ;
    endcase

    rgb = led_colour(lock_state_next, feedback_next);
    result.lock_state    = lock_state_next;
    result.feedback_kind = feedback_next;
    result.led_red       = rgb[23:16];
    result.led_green     = rgb[15:8];
    result.led_blue      = rgb[7:0];
    result.blink         = (lock_state_next == LS_ALARM) || (feedback_next != FB_NONE);
    result.fail_count    = fail_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_state     <= LS_LOCKED;
      feedback       <= FB_NONE;
      fail_counter   <= '0;
      fb_elapsed     <= '0;
      unlock_elapsed <= '0;
      alarm_elapsed  <= '0;
    end else if (accept) begin
      lock_state     <= lock_state_next;
      feedback       <= feedback_next;
      fail_counter   <= fail_counter_next;
      fb_elapsed     <= fb_elapsed_next;
      unlock_elapsed <= unlock_elapsed_next;
      alarm_elapsed  <= alarm_elapsed_next;
    end
  end

endmodule

### sv/kslc_out_buf.sv
// result register with skid entry
module kslc_out_buf
  import kslc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  out_word_t push_word,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      skid_valid;
  out_word_t skid_word;
  logic      take;

  assign take = out_valid && !out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_data   <= skid_word;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= push_word;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid) begin
        out_data  <= push_word;
        out_valid <= 1'b1;
      end else begin
        skid_word  <= push_word;
        skid_valid <= 1'b1;
      end
    end
  end

endmodule

### sv/keypad_lock_state_controller.sv
// top level of the keypad lock state controller
//
// event-driven lock controller: each input word carries one event (millisecond
// tick, remote lock, remote unlock, pin attempt with its pass bit, key press,
// or one of two configuration notices) and produces exactly one output word
// with the lock state, feedback kind, indicator colour, blink flag and the
// wrong-pin count after that event
// input channel: in_valid / in_stall / in_data, output channel: out_valid /
// out_stall / out_data; a word moves when valid is high and stall low
// the result word is formed combinationally and registered in the output stage
// throughput is one word per cycle while in_stall stays low
// a two-entry output stage (result register plus skid entry) lets a new word
// in while a finished result is still waiting; in_stall rises only once both
// entries hold results, so a stalled receiver backs up after two words
// configuration writes land on the next edge; the user must make them only while idle (not enforced)
// reset: lock locked, no feedback, counters cleared, timings at defaults
module keypad_lock_state_controller
  import kslc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t      cfg;
  out_word_t result;
  logic      buf_full;
  logic      accept;

  // stall only when both output entries are occupied
  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  // timing and limit registers
  kslc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // state machine, elapsed counters and result formation
  kslc_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_word (in_data),
    .cfg     (cfg),
    .result  (result)
  );

  // registered output with skid entry
  kslc_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_word (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### dv/keypad_lock_state_controller_tb.sv
// self-checking testbench for the keypad lock state controller
module keypad_lock_state_controller_tb
  import kslc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TIME_W      = TIME_BITS_DEF;
  localparam int          HALF_PERIOD = 5;
  localparam int          RESET_CYCLES = 10;
  // cycles with no word moving on either channel before the run is abandoned
  localparam int          STALL_LIMIT = 2000;
  // cycles allowed after the last expected word for stray output
  localparam int          TAIL_CYCLES = 10;
  localparam int          RANDOM_PHASES = 11;
  localparam int          PHASE_WORDS = 95;
  localparam int          HEAVY_WORDS = 420;
  // the one opcode value the block leaves unused
  localparam logic [2:0]  OP_UNUSED = 3'd7;

  // flavours of timing setting for the random phases
  localparam int unsigned SET_ZERO  = 0;
  localparam int unsigned SET_MAX   = 1;
  localparam int unsigned SET_WIDE  = 2;
  localparam int unsigned SET_SMALL = 3;

  // tracks the lock state the block should hold and the status words it owes
  class lock_tracker;
    cfg_t                cfg;
    lock_state_t         lock;
    logic [7:0]          wrong_count;
    fb_kind_t            fb;
    logic [TIME_W-1:0]   fb_elapsed;
    logic [TIME_W-1:0]   unlock_elapsed;
    logic [TIME_W-1:0]   alarm_elapsed;
    out_word_t           owed_status[$];
    int                  errors;

    function new();
      cfg.auto_lock_time    = AUTO_LOCK_RST;
      cfg.alarm_time        = ALARM_TIME_RST;
      cfg.fail_limit        = FAIL_LIMIT_RST;
      cfg.manual_mode       = MANUAL_RST;
      cfg.feedback_time     = FB_TIME_RST;
      cfg.key_feedback_time = KEY_FB_TIME_RST;
      lock           = LS_LOCKED;
      wrong_count    = '0;
      fb             = FB_NONE;
      fb_elapsed     = '0;
      unlock_elapsed = '0;
      alarm_elapsed  = '0;
      errors         = 0;
    endfunction

    function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_AUTO_LOCK:   cfg.auto_lock_time    = val;
        CFG_ALARM_TIME:  cfg.alarm_time        = val;
        CFG_FAIL_LIMIT:  cfg.fail_limit        = val[7:0];
        CFG_MANUAL_MODE: cfg.manual_mode       = val[0];
        CFG_FB_TIME:     cfg.feedback_time     = val;
        CFG_KEY_FB_TIME: cfg.key_feedback_time = val;
        default: ;
      endcase
    endfunction

    function logic [TIME_W-1:0] bump(logic [TIME_W-1:0] v);
      return (v == '1) ? v : v + TIME_W'(1);
    endfunction

    function void start_feedback(fb_kind_t kind);
      fb         = kind;
      fb_elapsed = '0;
    endfunction

    // advance the lock by one event word and queue the status it produces
    function void note_event(in_word_t w);
      logic [TIME_W-1:0] dur;
      out_word_t         s;
      case (w.opcode)
        OP_TICK: begin
          fb_elapsed     = bump(fb_elapsed);
          unlock_elapsed = bump(unlock_elapsed);
          alarm_elapsed  = bump(alarm_elapsed);
          if (fb != FB_NONE) begin
            dur = (fb == FB_KEY) ? cfg.key_feedback_time : cfg.feedback_time;
            if (fb_elapsed >= dur) fb = FB_NONE;
          end
          if (lock == LS_UNLOCKED && !cfg.manual_mode &&
              unlock_elapsed >= cfg.auto_lock_time) lock = LS_LOCKED;
          if (lock == LS_ALARM && alarm_elapsed >= cfg.alarm_time) lock = LS_LOCKED;
        end
        OP_R_LOCK: begin
          if (lock != LS_ALARM) begin
            lock = LS_LOCKED;
            start_feedback(FB_R_LOCK);
          end
        end
        OP_R_UNLOCK: begin
          if (lock != LS_ALARM) begin
            lock           = LS_UNLOCKED;
            unlock_elapsed = '0;
            start_feedback(FB_R_UNLOCK);
          end
        end
        OP_PIN: begin
          if (lock != LS_ALARM) begin
            if (w.pin_ok) begin
              wrong_count    = '0;
              lock           = LS_UNLOCKED;
              unlock_elapsed = '0;
            end else begin
              if (wrong_count != FAIL_MAX) wrong_count = wrong_count + 8'd1;
              if (wrong_count >= cfg.fail_limit) begin
                lock          = LS_ALARM;
                alarm_elapsed = '0;
                wrong_count   = '0;
                fb            = FB_NONE;
              end else begin
                start_feedback(FB_WRONG);
              end
            end
          end
        end
        OP_KEY: begin
          if (fb == FB_NONE || fb == FB_KEY) start_feedback(FB_KEY);
        end
        OP_CFG:     start_feedback(FB_CFG);
        OP_SEC_CFG: start_feedback(FB_SEC);
        default: ;
      endcase

      s.lock_state    = lock;
      s.feedback_kind = fb;
      s.led_red       = '0;
      s.led_green     = '0;
      s.led_blue      = '0;
      if (lock == LS_ALARM) begin
        s.led_red = LED_FULL;
      end else begin
        case (fb)
          FB_R_LOCK:   s.led_red = LED_FULL;
          FB_R_UNLOCK: s.led_green = LED_FULL;
          FB_CFG: begin
            s.led_green = LED_FULL;
            s.led_blue  = LED_FULL;
          end
          FB_SEC: begin
            s.led_red   = LED_FULL;
            s.led_green = LED_FULL;
          end
          FB_WRONG: begin
            s.led_red   = LED_FULL;
            s.led_green = LED_AMBER_GREEN;
          end
          FB_KEY: begin
            s.led_red   = LED_FULL;
            s.led_green = LED_FULL;
            s.led_blue  = LED_FULL;
          end
          default: begin
            if (lock == LS_LOCKED) s.led_red = LED_FULL;
            else if (lock == LS_UNLOCKED) s.led_green = LED_FULL;
          end
        endcase
      end
      s.blink      = (lock == LS_ALARM) || (fb != FB_NONE);
      s.fail_count = wrong_count;
      owed_status.push_back(s);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s expected %0d got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_status(out_word_t got);
      out_word_t want;
      if (owed_status.size() == 0) begin
        $error("status word %h arrived with none expected", got);
        errors++;
        return;
      end
      want = owed_status.pop_front();
      compare("lock_state", 8'(want.lock_state), 8'(got.lock_state));
      compare("feedback_kind", 8'(want.feedback_kind), 8'(got.feedback_kind));
      compare("led_red", want.led_red, got.led_red);
      compare("led_green", want.led_green, got.led_green);
      compare("led_blue", want.led_blue, got.led_blue);
      compare("blink", 8'(want.blink), 8'(got.blink));
      compare("fail_count", want.fail_count, got.fail_count);
    endfunction

    function int owed();
      return owed_status.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_word_t             out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lock_tracker tracker;
  // set while a phase runs with both sides flowing freely
  bit          calm = 1'b0;
  int          quiet_cycles;

  keypad_lock_state_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // a 38 in a hundred chance of a break, none during a calm phase
  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 38);
  endfunction

  function automatic in_word_t word_of(logic [2:0] op, logic ok);
    in_word_t w;
    w.opcode = op;
    w.pin_ok = ok;
    return w;
  endfunction

  // event mix: ticks dominate (pins in the wrong-heavy mix) so the timers run out; pin_ok is
  // randomised on every opcode but a wrong-heavy pin, so its bit toggles outside pin attempts too
  function automatic in_word_t random_word(bit wrong_heavy);
    in_word_t    w;
    int unsigned r;
    w.pin_ok = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 99);
    if (wrong_heavy) begin
      // long runs of wrong pins, never a correct one, to walk the count up
      if (r < 80) begin
        w.opcode = OP_PIN;
        w.pin_ok = 1'b0;
      end else begin
        w.opcode = 3'($urandom_range(0, 7));
        if (w.opcode == OP_PIN) w.pin_ok = 1'b0;
      end
    end else if (r < 45) w.opcode = OP_TICK;
    else if (r < 52)     w.opcode = OP_R_LOCK;
    else if (r < 60)     w.opcode = OP_R_UNLOCK;
    else if (r < 78)     w.opcode = OP_PIN;
    else if (r < 89)     w.opcode = OP_KEY;
    else if (r < 93)     w.opcode = OP_CFG;
    else if (r < 97)     w.opcode = OP_SEC_CFG;
    else                 w.opcode = OP_UNUSED;
    return w;
  endfunction

  // zero, all-ones, wide random or small timings; small ones keep expiry, relock and alarm clearing frequent
  function automatic cfg_t pick_setting(int unsigned flavour);
    cfg_t s;
    case (flavour)
      SET_ZERO: s = '0;
      SET_MAX:  s = '1;
      SET_WIDE: begin
        s.auto_lock_time    = CFG_TIME_W'($urandom());
        s.alarm_time        = CFG_TIME_W'($urandom());
        s.fail_limit        = 8'($urandom_range(0, 255));
        s.manual_mode       = 1'($urandom_range(0, 1));
        s.feedback_time     = CFG_TIME_W'($urandom());
        s.key_feedback_time = CFG_TIME_W'($urandom());
      end
      default: begin
        s.auto_lock_time    = CFG_TIME_W'($urandom_range(0, 15));
        s.alarm_time        = CFG_TIME_W'($urandom_range(0, 15));
        s.fail_limit        = 8'($urandom_range(0, 6));
        s.manual_mode       = 1'($urandom_range(0, 1));
        s.feedback_time     = CFG_TIME_W'($urandom_range(0, 15));
        s.key_feedback_time = CFG_TIME_W'($urandom_range(0, 15));
      end
    endcase
    return s;
  endfunction

  // present one event word at a falling edge and hold it until taken
  task automatic send_word(in_word_t w);
    in_valid = 1'b0;
    while (take_break()) @(negedge clk);
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // stop sending and wait for every owed status word to come back
  task automatic drain();
    in_valid = 1'b0;
    while (tracker.owed() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    tracker.set_register(idx, val);
    @(negedge clk);
  endtask

  // every register is rewritten on each change of setting
  task automatic load_setting(cfg_t s);
    write_reg(CFG_AUTO_LOCK, s.auto_lock_time);
    write_reg(CFG_ALARM_TIME, s.alarm_time);
    write_reg(CFG_FAIL_LIMIT, CFG_DATA_W'(s.fail_limit));
    write_reg(CFG_MANUAL_MODE, CFG_DATA_W'(s.manual_mode));
    write_reg(CFG_FB_TIME, s.feedback_time);
    write_reg(CFG_KEY_FB_TIME, s.key_feedback_time);
    cfg_wr_en = 1'b0;
    @(negedge clk);
  endtask

  // receiver side: stall decided afresh at every falling edge
  always @(negedge clk) begin
    out_stall = take_break();
  end

  // both channels sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    bit progress;
    progress = 1'b0;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        tracker.note_event(in_data);
        progress = 1'b1;
      end
      if (out_valid && !out_stall) begin
        tracker.check_status(out_data);
        progress = 1'b1;
      end
      quiet_cycles <= progress ? 0 : quiet_cycles + 1;
    end
  end

  // watchdog: nothing moving on either channel for too long
  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("keypad_lock_state_controller test failed");
    $finish;
  end

  initial begin
    cfg_t        s;
    int unsigned flavour;
    int          words;
    bit          heavy;

    tracker      = new();
    quiet_cycles = 0;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset timings: every opcode, the unused one, and the alarm path
    send_word(word_of(OP_TICK, 1'b0));
    send_word(word_of(OP_UNUSED, 1'b1));
    send_word(word_of(OP_R_LOCK, 1'b0));
    // key press over another feedback is ignored
    send_word(word_of(OP_KEY, 1'b0));
    send_word(word_of(OP_R_UNLOCK, 1'b1));
    send_word(word_of(OP_PIN, 1'b1));
    send_word(word_of(OP_PIN, 1'b0));
    send_word(word_of(OP_PIN, 1'b0));
    // third wrong pin reaches the limit and raises the alarm
    send_word(word_of(OP_PIN, 1'b0));
    // pins and remote commands are ignored while the alarm is up
    send_word(word_of(OP_PIN, 1'b1));
    send_word(word_of(OP_R_LOCK, 1'b1));
    send_word(word_of(OP_R_UNLOCK, 1'b0));
    // key feedback still starts, and restarts, during the alarm
    send_word(word_of(OP_KEY, 1'b1));
    send_word(word_of(OP_KEY, 1'b0));
    send_word(word_of(OP_CFG, 1'b0));
    send_word(word_of(OP_SEC_CFG, 1'b1));
    send_word(word_of(OP_TICK, 1'b1));
    drain();

    // short timings and a zero limit: expiry, relock and alarm clearing
    s.auto_lock_time    = 24'd2;
    s.alarm_time        = 24'd3;
    s.fail_limit        = 8'd0;
    s.manual_mode       = 1'b0;
    s.feedback_time     = 24'd2;
    s.key_feedback_time = 24'd1;
    load_setting(s);
    // a zero limit would alarm on the first wrong pin, but the alarm from above is still up, so this one is ignored
    send_word(word_of(OP_PIN, 1'b0));
    repeat (3) send_word(word_of(OP_TICK, 1'b0));
    send_word(word_of(OP_R_UNLOCK, 1'b0));
    repeat (2) send_word(word_of(OP_TICK, 1'b0));
    send_word(word_of(OP_KEY, 1'b0));
    send_word(word_of(OP_TICK, 1'b0));
    drain();

    // random phases, one timing setting each
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0)      flavour = SET_ZERO;
      else if (p == 1) flavour = SET_MAX;
      else if (p == 3) flavour = SET_WIDE;
      else             flavour = SET_SMALL;
      // limit of 255 with manual mode: long wrong-pin runs walk the count up to the alarm
      heavy = (p == 1);
      words = heavy ? HEAVY_WORDS : PHASE_WORDS;
      load_setting(pick_setting(flavour));
      calm = (p == 2);
      for (int i = 0; i < words; i++) send_word(random_word(heavy));
      drain();
      calm = 1'b0;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.owed() == 0) begin
      $display("keypad_lock_state_controller test passed");
    end else begin
      $display("keypad_lock_state_controller test failed");
    end
    $finish;
  end

endmodule

### filelist.f
sv/kslc_pkg.sv
sv/kslc_cfg_regs.sv
sv/kslc_core.sv
sv/kslc_out_buf.sv
sv/keypad_lock_state_controller.sv
dv/keypad_lock_state_controller_tb.sv
